>>> src/gmd_pkg.sv
`default_nettype none
package gmd_pkg;

	localparam int MAX_SIDE_DEF = 32;
	localparam int RESET_SIDE   = 8;

	// cell word: visited flag over four wall bits
	localparam int CELL_W = 5;

	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_STEP  = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;
	localparam logic [1:0] REQ_NONE  = 2'd3;

	localparam logic [2:0] ST_STARTED  = 3'd0;
	localparam logic [2:0] ST_CARVED   = 3'd1;
	localparam logic [2:0] ST_BACKED   = 3'd2;
	localparam logic [2:0] ST_COMPLETE = 3'd3;
	localparam logic [2:0] ST_READ     = 3'd4;

	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_LEFT  = 2'd1;
	localparam logic [1:0] DIR_DOWN  = 2'd2;
	localparam logic [1:0] DIR_RIGHT = 2'd3;

	localparam logic [3:0] WALL_RIGHT = 4'd1;
	localparam logic [3:0] WALL_UP    = 4'd2;
	localparam logic [3:0] WALL_LEFT  = 4'd4;
	localparam logic [3:0] WALL_DOWN  = 4'd8;
	localparam logic [3:0] WALL_ALL   = 4'hF;

	// wall of the current cell that faces direction d
	function automatic logic [3:0] own_mask(input logic [1:0] d);
		logic [3:0] m;
		unique case (d)
			DIR_UP:   m = WALL_UP;
			DIR_LEFT: m = WALL_LEFT;
			DIR_DOWN: m = WALL_DOWN;
			default:  m = WALL_RIGHT;
		endcase
		return m;
	endfunction

	// wall of the neighbor that faces back toward the current cell
	function automatic logic [3:0] far_mask(input logic [1:0] d);
		logic [3:0] m;
		unique case (d)
			DIR_UP:   m = WALL_DOWN;
			DIR_LEFT: m = WALL_RIGHT;
			DIR_DOWN: m = WALL_UP;
			default:  m = WALL_LEFT;
		endcase
		return m;
	endfunction

	// residue mod 3 by folding base-4 digits (4 = 1 mod 3)
	function automatic logic [1:0] mod3_16(input logic [15:0] v);
		logic [4:0] s;
		logic [2:0] s2;
		logic [2:0] s3;
		s = 5'(v[1:0]) + 5'(v[3:2]) + 5'(v[5:4]) + 5'(v[7:6])
			+ 5'(v[9:8]) + 5'(v[11:10]) + 5'(v[13:12]) + 5'(v[15:14]);
		s2 = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
		s3 = 3'(s2[1:0]) + 3'(s2[2]);
		return (s3 >= 3'd3) ? 2'(s3 - 3'd3) : 2'(s3);
	endfunction

endpackage
`default_nettype wire

>>> src/gmd_ram.sv
`default_nettype none
module gmd_ram #(
	parameter int W     = 5,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [W-1:0]             wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

>>> src/grid_maze_dfs_generator.sv
`default_nettype none
// Depth-first maze generator over a cell memory and a walk stack memory.
// Each accepted request ends in a result strobe on done, and busy drops in the
// strobe cycle. One request at a time; throughput is set by the cell memory,
// which has one read and one write port and, for a forward step, reads four
// neighbors and the current cell and writes two cells.
// Reset and every start sweep all CAP = MAX_SIDE*MAX_SIDE cells of the cell memory.
module grid_maze_dfs_generator #(
	parameter int MAX_SIDE = gmd_pkg::MAX_SIDE_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [1:0] req_type,
	input  wire logic [15:0] random_word,
	input  wire logic [9:0] read_cell,
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [5:0] cfg_data,
	output logic            done,
	output logic [2:0]      status,
	output logic [9:0]      cell_out,
	output logic [3:0]      walls_out,
	output logic [1:0]      carve_dir
);
	import gmd_pkg::*;

	localparam int CAP = MAX_SIDE * MAX_SIDE;
	localparam int AW  = $clog2(CAP);
	localparam int SW  = $clog2(MAX_SIDE + 1);
	localparam int CB  = $clog2(MAX_SIDE);
	localparam int XW  = (AW > 10) ? AW : 10;
	localparam int RS  = (RESET_SIDE > MAX_SIDE) ? MAX_SIDE : RESET_SIDE;

	typedef enum logic [3:0] {
		S_IDLE, S_TOTAL, S_CLEAR, S_RUP, S_RLEFT, S_RDOWN, S_RRIGHT, S_RCUR,
		S_DECIDE, S_WNEXT, S_POP, S_POPCELL, S_RONE, S_EMIT
	} state_t;

	function automatic logic [SW-1:0] clamp_side(input logic [5:0] v);
		logic [SW-1:0] r;
		if (v < 6'd3) begin
			r = SW'(3);
		end else if (int'(v) > MAX_SIDE) begin
			r = SW'(MAX_SIDE);
		end else begin
			r = SW'(v);
		end
		return r;
	endfunction

	state_t          state_q;
	logic [5:0]      cfg_w_q, cfg_h_q;
	logic [SW-1:0]   use_w_q, use_h_q;
	logic [AW:0]     total_q, vcount_q, depth_q;
	logic [AW-1:0]   sweep_q, cur_q, addr_q, next_q;
	logic [CB-1:0]   row_q, col_q, nrow_q, ncol_q;
	logic            init_q, zero_q;
	logic [15:0]     rnd_q;
	logic [CELL_W-1:0] nb_q [4];
	logic [3:0]      nwall_q;
	logic [1:0]      dir_q;
	logic [2:0]      st_q;
	logic [9:0]      ocell_q;

	logic              c_we;
	logic [AW-1:0]     c_waddr, c_raddr;
	logic [CELL_W-1:0] c_wdata, c_rdata;
	logic              k_we;
	logic [AW-1:0]     k_raddr;
	logic [2*CB-1:0]   k_rdata;

	gmd_ram #(.W(CELL_W), .DEPTH(CAP)) u_cells (
		.clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
		.raddr(c_raddr), .rdata(c_rdata)
	);

	gmd_ram #(.W(2 * CB), .DEPTH(CAP)) u_stack (
		.clk(clk), .we(k_we), .waddr(depth_q[AW-1:0]), .wdata({nrow_q, ncol_q}),
		.raddr(k_raddr), .rdata(k_rdata)
	);

	// neighbor choice
	logic [3:0]    avail;
	logic [2:0]    cnt;
	logic [1:0]    pick, dsel;
	logic          any;
	logic [AW-1:0] ncell;
	logic [CB-1:0] nrow, ncol;
	logic [AW-1:0] pop_cell;
	logic [XW-1:0] rd_x;

	always_comb begin
		logic [1:0] seen;
		logic       found;
		avail[0] = (row_q != '0) && !nb_q[0][4];
		avail[1] = (col_q != '0) && !nb_q[1][4];
		avail[2] = (SW'(row_q) + SW'(1) < use_h_q) && !nb_q[2][4];
		avail[3] = (SW'(col_q) + SW'(1) < use_w_q) && !nb_q[3][4];
		cnt = 3'(avail[0]) + 3'(avail[1]) + 3'(avail[2]) + 3'(avail[3]);
		any = (cnt != 3'd0);
		unique case (cnt)
			3'd2:    pick = {1'b0, rnd_q[0]};
			3'd3:    pick = mod3_16(rnd_q);
			3'd4:    pick = rnd_q[1:0];
			default: pick = 2'd0;
		endcase
		seen = 2'd0;
		found = 1'b0;
		dsel = DIR_UP;
		for (int i = 0; i < 4; i++) begin
			if (avail[i] && !found && seen == pick) begin
				dsel = 2'(i);
				found = 1'b1;
			end
			if (avail[i]) begin
				seen = seen + 2'd1;
			end
		end
		nrow = row_q;
		ncol = col_q;
		unique case (dsel)
			DIR_UP: begin
				ncell = cur_q - AW'(use_w_q);
				nrow = row_q - CB'(1);
			end
			DIR_LEFT: begin
				ncell = cur_q - AW'(1);
				ncol = col_q - CB'(1);
			end
			DIR_DOWN: begin
				ncell = cur_q + AW'(use_w_q);
				nrow = row_q + CB'(1);
			end
			default: begin
				ncell = cur_q + AW'(1);
				ncol = col_q + CB'(1);
			end
		endcase
		pop_cell = AW'(k_rdata[2*CB-1:CB]) * AW'(use_w_q) + AW'(k_rdata[CB-1:0]);
		rd_x = XW'(read_cell);
	end

	// memory port control
	always_comb begin
		c_we = 1'b0;
		c_waddr = cur_q;
		c_wdata = c_rdata;
		unique case (state_q)
			S_RUP:    c_raddr = cur_q - AW'(use_w_q);
			S_RLEFT:  c_raddr = cur_q - AW'(1);
			S_RDOWN:  c_raddr = cur_q + AW'(use_w_q);
			S_RRIGHT: c_raddr = cur_q + AW'(1);
			S_RONE:   c_raddr = addr_q;
			default:  c_raddr = cur_q;
		endcase
		if (state_q == S_CLEAR) begin
			c_we = 1'b1;
			c_waddr = sweep_q;
			if (init_q && sweep_q == '0) begin
				c_wdata = {1'b1, WALL_ALL & ~WALL_LEFT};
			end else if (init_q && {1'b0, sweep_q} == total_q - (AW+1)'(1)) begin
				c_wdata = {1'b0, WALL_ALL & ~WALL_RIGHT};
			end else begin
				c_wdata = {1'b0, WALL_ALL};
			end
		end else if (state_q == S_DECIDE && any) begin
			c_we = 1'b1;
			c_wdata = {c_rdata[4], c_rdata[3:0] & ~own_mask(dsel)};
		end else if (state_q == S_WNEXT) begin
			c_we = 1'b1;
			c_waddr = next_q;
			c_wdata = {1'b1, nwall_q};
		end
		k_we = (state_q == S_WNEXT) && (depth_q < (AW+1)'(CAP));
		k_raddr = AW'(depth_q - (AW+1)'(1));
	end

	assign busy = (state_q != S_IDLE);

	// sequencer with registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cfg_w_q <= 6'(RESET_SIDE);
			cfg_h_q <= 6'(RESET_SIDE);
			use_w_q <= SW'(RS);
			use_h_q <= SW'(RS);
			total_q <= (AW+1)'(RS * RS);
			vcount_q <= (AW+1)'(1);
			depth_q <= '0;
			sweep_q <= '0;
			cur_q <= '0;
			row_q <= '0;
			col_q <= '0;
			addr_q <= '0;
			next_q <= '0;
			nrow_q <= '0;
			ncol_q <= '0;
			init_q <= 1'b0;
			zero_q <= 1'b0;
			rnd_q <= '0;
			for (int i = 0; i < 4; i++) nb_q[i] <= '0;
			nwall_q <= '0;
			dir_q <= DIR_UP;
			st_q <= ST_STARTED;
			ocell_q <= '0;
			done <= 1'b0;
			status <= ST_STARTED;
			cell_out <= '0;
			walls_out <= '0;
			carve_dir <= DIR_UP;
		end else begin
			done <= 1'b0;
			// hold register writes until the next start
			if (cfg_we) begin
				if (cfg_index) cfg_h_q <= cfg_data;
				else cfg_w_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						rnd_q <= random_word;
						unique case (req_type)
							REQ_START: begin
								use_w_q <= clamp_side(cfg_w_q);
								use_h_q <= clamp_side(cfg_h_q);
								state_q <= S_TOTAL;
							end
							REQ_STEP: begin
								if (vcount_q >= total_q) begin
									addr_q <= cur_q;
									ocell_q <= 10'(cur_q);
									zero_q <= 1'b0;
									st_q <= ST_COMPLETE;
									state_q <= S_RONE;
								end else begin
									state_q <= S_RUP;
								end
							end
							REQ_READ: begin
								addr_q <= rd_x[AW-1:0];
								ocell_q <= read_cell;
								zero_q <= ({1'b0, rd_x} >= (XW+1)'(CAP));
								st_q <= ST_READ;
								state_q <= S_RONE;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_TOTAL: begin
					total_q <= (AW+1)'(use_w_q) * (AW+1)'(use_h_q);
					vcount_q <= (AW+1)'(1);
					depth_q <= '0;
					init_q <= 1'b1;
					sweep_q <= '0;
					state_q <= S_CLEAR;
				end
				S_CLEAR: begin
					// advance the sweep; finish with a fresh walk
					sweep_q <= sweep_q + AW'(1);
					if (sweep_q == AW'(CAP - 1)) begin
						cur_q <= '0;
						row_q <= '0;
						col_q <= '0;
						depth_q <= '0;
						vcount_q <= (AW+1)'(1);
						state_q <= S_IDLE;
						if (init_q) begin
							done <= 1'b1;
							status <= ST_STARTED;
							cell_out <= '0;
							walls_out <= WALL_ALL & ~WALL_LEFT;
							carve_dir <= DIR_UP;
						end
					end
				end
				S_RUP:    state_q <= S_RLEFT;
				S_RLEFT: begin
					nb_q[0] <= c_rdata;
					state_q <= S_RDOWN;
				end
				S_RDOWN: begin
					nb_q[1] <= c_rdata;
					state_q <= S_RRIGHT;
				end
				S_RRIGHT: begin
					nb_q[2] <= c_rdata;
					state_q <= S_RCUR;
				end
				S_RCUR: begin
					nb_q[3] <= c_rdata;
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					// carve toward the chosen neighbor, back up, or report a dead end at the stack bottom
					if (any) begin
						next_q <= ncell;
						nrow_q <= nrow;
						ncol_q <= ncol;
						dir_q <= dsel;
						nwall_q <= nb_q[dsel][3:0] & ~far_mask(dsel);
						state_q <= S_WNEXT;
					end else if (depth_q != '0) begin
						state_q <= S_POP;
					end else begin
						done <= 1'b1;
						status <= ST_BACKED;
						cell_out <= 10'(cur_q);
						walls_out <= c_rdata[3:0];
						carve_dir <= DIR_UP;
						state_q <= S_IDLE;
					end
				end
				S_WNEXT: begin
					cur_q <= next_q;
					row_q <= nrow_q;
					col_q <= ncol_q;
					vcount_q <= vcount_q + (AW+1)'(1);
					if (depth_q < (AW+1)'(CAP)) depth_q <= depth_q + (AW+1)'(1);
					done <= 1'b1;
					status <= ST_CARVED;
					cell_out <= 10'(next_q);
					walls_out <= nwall_q;
					carve_dir <= dir_q;
					state_q <= S_IDLE;
				end
				S_POP: begin
					depth_q <= depth_q - (AW+1)'(1);
					state_q <= S_POPCELL;
				end
				S_POPCELL: begin
					cur_q <= pop_cell;
					row_q <= k_rdata[2*CB-1:CB];
					col_q <= k_rdata[CB-1:0];
					addr_q <= pop_cell;
					ocell_q <= 10'(pop_cell);
					zero_q <= 1'b0;
					st_q <= ST_BACKED;
					state_q <= S_RONE;
				end
				S_RONE:   state_q <= S_EMIT;
				S_EMIT: begin
					done <= 1'b1;
					status <= st_q;
					cell_out <= ocell_q;
					walls_out <= zero_q ? 4'd0 : c_rdata[3:0];
					carve_dir <= DIR_UP;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("back-to-back result strobes");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req_type != REQ_NONE) |=> busy)
		else $error("accepted request did not occupy the block");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= vcount_q) else $error("stack deeper than visited cells");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vcount_q <= total_q) else $error("visited count beyond grid size");

endmodule
`default_nettype wire
